@@ sv/tlbpt_pkg.sv @@
// Shared types and fixed constants for the TLB and page table translator.
// No dependencies; imported by the translator top level.
`default_nettype none

package tlbpt_pkg;

    localparam int ADDR_W      = 16;
    localparam int FRAME_OUT_W = 8;
    localparam int CNT_W       = 32;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QUO,
        ST_SPLIT,
        ST_PAGE,
        ST_LOOK,
        ST_MAP
    } t_state;

endpackage

`default_nettype wire

@@ sv/tlbpt_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module tlbpt_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ sv/tlbpt_cam.sv @@
// Fully associative TLB with FIFO replacement, held in flip-flops.
// No dependencies; instantiated by the translator top level.
`default_nettype none

module tlbpt_cam #(
    parameter int ENTRIES = 16,
    parameter int TAG_W   = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_lookup,
    input  wire logic [TAG_W-1:0] i_lookup_page,
    output logic                  o_hit,
    output logic      [TAG_W-1:0] o_frame,
    input  wire logic             i_wr_en,
    input  wire logic [TAG_W-1:0] i_wr_page,
    input  wire logic [TAG_W-1:0] i_wr_frame
);

    localparam int IDX_W = $clog2(ENTRIES);

    logic             r_valid [ENTRIES];
    logic [TAG_W-1:0] r_tag   [ENTRIES];
    logic [TAG_W-1:0] r_frame [ENTRIES];
    logic [IDX_W-1:0] r_fill;

    logic [ENTRIES-1:0] w_match;
    logic               w_hit;
    logic [TAG_W-1:0]   w_frame;

    // Walk from the top down so the lowest-numbered matching slot wins.
    always_comb begin
        w_hit   = 1'b0;
        w_frame = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            w_match[i] = r_valid[i] && (r_tag[i] == i_lookup_page);
            if (w_match[i]) begin
                w_hit   = 1'b1;
                w_frame = r_frame[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
            end
            r_fill <= '0;
            o_hit  <= 1'b0;
        end else begin
            if (i_lookup) begin
                o_hit <= w_hit;
            end
            if (i_wr_en) begin
                r_valid[r_fill] <= 1'b1;
                if (r_fill == IDX_W'(ENTRIES - 1)) begin
                    r_fill <= '0;
                end else begin
                    r_fill <= r_fill + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_lookup) begin
            o_frame <= w_frame;
        end
        if (i_wr_en) begin
            r_tag[r_fill]   <= i_wr_page;
            r_frame[r_fill] <= i_wr_frame;
        end
    end

endmodule

`default_nettype wire

@@ sv/tlb_page_table_translator_core.sv @@
// Translator top level: address split, TLB lookup, page table RAM and frame allocation.
// Depends on tlbpt_pkg, tlbpt_cam and tlbpt_ram.
`default_nettype none

// A request is taken when start is high and busy is low. The address is split into page
// and offset in states ST_QUO, ST_SPLIT and ST_PAGE (two reciprocal multiplications and
// the remainders), the TLB and the page table RAM are read in ST_LOOK, and ST_MAP resolves
// hit, mapping or fault, refills the TLB on a miss and the page table on a fault; the result
// shows on the o_ ports with o_result_valid for one cycle as busy drops, and the block takes
// no new request before then. The receiver cannot stall.
// After reset the page table RAM is cleared one entry per cycle, so busy stays high
// until all PAGE_COUNT entries are cleared, and no request is taken before that.
module tlb_page_table_translator_core #(
    parameter int TLB_ENTRIES = 16,
    parameter int PAGE_BYTES  = 256,
    parameter int PAGE_COUNT  = 256
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [tlbpt_pkg::ADDR_W-1:0]       i_logical_address,
    output logic                                    o_result_valid,
    output logic      [tlbpt_pkg::ADDR_W-1:0]       o_physical_address,
    output logic      [tlbpt_pkg::FRAME_OUT_W-1:0]  o_frame_number,
    output logic                                    o_tlb_hit,
    output logic                                    o_page_fault,
    output logic      [tlbpt_pkg::CNT_W-1:0]        o_hits_so_far,
    output logic      [tlbpt_pkg::CNT_W-1:0]        o_faults_so_far
);

    import tlbpt_pkg::*;

    localparam int PAGE_W  = $clog2(PAGE_COUNT);
    localparam int OFF_W   = $clog2(PAGE_BYTES);
    localparam int QUO_MAX = 65535 / PAGE_BYTES;
    localparam int QUO_W   = $clog2(QUO_MAX + 1);

    // Address divided by PAGE_BYTES through an exact rounded-up reciprocal.
    localparam int S1   = ADDR_W + $clog2(PAGE_BYTES);
    localparam int M1_W = ADDR_W + 1;
    localparam int P1_W = ADDR_W + M1_W;
    localparam longint unsigned M1_FULL = ((64'd1 << S1) + PAGE_BYTES - 1) / PAGE_BYTES;
    localparam logic [M1_W-1:0] M1 = M1_W'(M1_FULL);

    // Quotient reduced modulo PAGE_COUNT the same way.
    localparam int S2   = QUO_W + $clog2(PAGE_COUNT);
    localparam int M2_W = QUO_W + 1;
    localparam int P2_W = S2 + QUO_W;
    localparam longint unsigned M2_FULL = ((64'd1 << S2) + PAGE_COUNT - 1) / PAGE_COUNT;
    localparam logic [M2_W-1:0] M2 = M2_W'(M2_FULL);

    t_state r_state, n_state;

    logic [ADDR_W-1:0] r_addr;
    logic [QUO_W-1:0]  r_quo;
    logic [QUO_W-1:0]  r_pq;
    logic [OFF_W-1:0]  r_offset;
    logic [PAGE_W-1:0] r_page;
    logic [PAGE_W-1:0] r_clr_addr;
    logic [PAGE_W:0]   r_next_free;
    logic [CNT_W-1:0]  r_hits;
    logic [CNT_W-1:0]  r_faults;

    logic [P1_W-1:0]   w_prod1;
    logic [P2_W-1:0]   w_prod2;
    logic [ADDR_W-1:0] w_off_full;
    logic [ADDR_W-1:0] w_page_full;

    logic              w_cam_hit;
    logic [PAGE_W-1:0] w_cam_frame;
    logic              w_tlb_wr;

    logic              w_ram_we;
    logic [PAGE_W-1:0] w_ram_waddr;
    logic [PAGE_W:0]   w_ram_wdata;
    logic [PAGE_W:0]   w_ram_rdata;
    logic              w_map_valid;

    logic              w_fault;
    logic [PAGE_W-1:0] w_alloc;
    logic [PAGE_W-1:0] w_frame;
    logic [31:0]       w_frame32;
    logic [31:0]       w_phys32;

    tlbpt_cam #(
        .ENTRIES (TLB_ENTRIES),
        .TAG_W   (PAGE_W)
    ) u_cam (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_lookup      (r_state == ST_LOOK),
        .i_lookup_page (r_page),
        .o_hit         (w_cam_hit),
        .o_frame       (w_cam_frame),
        .i_wr_en       (w_tlb_wr),
        .i_wr_page     (r_page),
        .i_wr_frame    (w_frame)
    );

    // Each word holds a valid bit above the frame number.
    tlbpt_ram #(
        .WIDTH (PAGE_W + 1),
        .DEPTH (PAGE_COUNT)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (r_page),
        .o_rdata (w_ram_rdata)
    );

    assign w_prod1     = P1_W'(r_addr) * P1_W'(M1);
    assign w_prod2     = P2_W'(r_quo) * P2_W'(M2);
    assign w_off_full  = r_addr - ADDR_W'(r_quo) * ADDR_W'(PAGE_BYTES);
    assign w_page_full = ADDR_W'(r_quo) - ADDR_W'(r_pq) * ADDR_W'(PAGE_COUNT);

    assign w_map_valid = w_ram_rdata[PAGE_W];
    assign w_alloc     = (r_next_free < (PAGE_W + 1)'(PAGE_COUNT)) ?
                         r_next_free[PAGE_W-1:0] : '0;
    assign w_fault     = !w_cam_hit && !w_map_valid;
    assign w_frame     = w_cam_hit   ? w_cam_frame :
                         w_map_valid ? w_ram_rdata[PAGE_W-1:0] : w_alloc;
    assign w_frame32   = 32'(w_frame);
    assign w_phys32    = w_frame32 * 32'(PAGE_BYTES) + 32'(r_offset);

    assign busy = (r_state != ST_IDLE);

    always_comb begin
        n_state     = r_state;
        w_ram_we    = 1'b0;
        w_ram_waddr = r_page;
        w_ram_wdata = {1'b1, w_alloc};
        w_tlb_wr    = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_clr_addr;
                w_ram_wdata = '0;
                if (r_clr_addr == PAGE_W'(PAGE_COUNT - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_QUO;
                end
            end
            ST_QUO:   n_state = ST_SPLIT;
            ST_SPLIT: n_state = ST_PAGE;
            ST_PAGE:  n_state = ST_LOOK;
            ST_LOOK:  n_state = ST_MAP;
            ST_MAP: begin
                w_ram_we = w_fault;
                w_tlb_wr = !w_cam_hit;
                n_state  = ST_IDLE;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_CLEAR;
            r_clr_addr     <= '0;
            r_next_free    <= '0;
            r_hits         <= '0;
            r_faults       <= '0;
            o_result_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            o_result_valid <= (r_state == ST_MAP);
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (r_state == ST_MAP) begin
                if (w_cam_hit && r_hits != CNT_MAX) begin
                    r_hits <= r_hits + 1'b1;
                end
                if (w_fault) begin
                    if (r_faults != CNT_MAX) begin
                        r_faults <= r_faults + 1'b1;
                    end
                    if (r_next_free < (PAGE_W + 1)'(PAGE_COUNT)) begin
                        r_next_free <= r_next_free + 1'b1;
                    end
                end
            end
        end
    end

    // Datapath registers; the counters feed the result ports as they are updated.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && start) begin
            r_addr <= i_logical_address;
        end
        if (r_state == ST_QUO) begin
            r_quo <= w_prod1[S1 +: QUO_W];
        end
        if (r_state == ST_SPLIT) begin
            r_offset <= w_off_full[OFF_W-1:0];
            r_pq     <= w_prod2[S2 +: QUO_W];
        end
        if (r_state == ST_PAGE) begin
            r_page <= w_page_full[PAGE_W-1:0];
        end
        if (r_state == ST_MAP) begin
            o_physical_address <= w_phys32[ADDR_W-1:0];
            o_frame_number     <= w_frame32[FRAME_OUT_W-1:0];
            o_tlb_hit          <= w_cam_hit;
            o_page_fault       <= w_fault;
            o_hits_so_far      <= (w_cam_hit && r_hits != CNT_MAX) ? r_hits + 1'b1 : r_hits;
            o_faults_so_far    <= (w_fault && r_faults != CNT_MAX) ? r_faults + 1'b1 :
                                  r_faults;
        end
    end

    a_strobe_follows_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_state == ST_MAP))
        else $error("result strobe without a resolve cycle");

    a_hit_excludes_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !(o_tlb_hit && o_page_fault))
        else $error("TLB hit reported together with a page fault");

    a_accept_starts_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == ST_QUO))
        else $error("accepted request did not enter the address split");

    a_ram_write_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> (r_state == ST_MAP || r_state == ST_CLEAR))
        else $error("page table written outside resolve or clearing");

    a_alloc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_free <= (PAGE_W + 1)'(PAGE_COUNT))
        else $error("free frame pointer ran past the frame count");

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for tlb_page_table_translator_core: a predictor of the TLB,
// the page table and the running counts checks every translation result in order.
// Depends on tlbpt_pkg and the translator RTL; needs no other files.

module tb_top;
    import tlbpt_pkg::*;

    localparam int TLB_ENTRIES     = 16;
    localparam int PAGE_BYTES      = 256;
    localparam int PAGE_COUNT      = 256;
    localparam int PAGE_W          = $clog2(PAGE_COUNT);
    localparam int RANDOM_REQUESTS = 600;
    localparam int RECENT_DEPTH    = 12;
    localparam int DRAIN_CYCLES    = 20;
    localparam int CYCLE_LIMIT     = 200000;

    typedef struct packed {
        logic [ADDR_W-1:0]      phys_addr;
        logic [FRAME_OUT_W-1:0] frame;
        logic                   tlb_hit;
        logic                   page_fault;
        logic [CNT_W-1:0]       hits;
        logic [CNT_W-1:0]       faults;
    } t_xlat;

    // Predicts each translation and keeps the expected results in request order.
    class xlat_scoreboard;
        bit               tlb_live  [TLB_ENTRIES];
        int unsigned      tlb_page  [TLB_ENTRIES];
        int unsigned      tlb_frame [TLB_ENTRIES];
        int unsigned      tlb_victim;
        bit               pt_mapped [PAGE_COUNT];
        int unsigned      pt_frame  [PAGE_COUNT];
        int unsigned      frames_used;
        logic [CNT_W-1:0] hit_count;
        logic [CNT_W-1:0] fault_count;
        t_xlat            pending_xlat [$];
        int               error_count;

        function new();
            foreach (tlb_live[i]) tlb_live[i] = 1'b0;
            foreach (pt_mapped[i]) pt_mapped[i] = 1'b0;
            tlb_victim  = 0;
            frames_used = 0;
            hit_count   = '0;
            fault_count = '0;
            error_count = 0;
        endfunction

        function void note_request(input logic [ADDR_W-1:0] addr);
            int unsigned page;
            int unsigned offset;
            int unsigned frame;
            bit          hit;
            bit          fault;
            t_xlat       want;
            page   = (addr / PAGE_BYTES) % PAGE_COUNT;
            offset = addr % PAGE_BYTES;
            frame  = 0;
            hit    = 1'b0;
            fault  = 1'b0;
            // The lowest-numbered matching slot wins.
            for (int slot = 0; slot < TLB_ENTRIES; slot++) begin
                if (!hit && tlb_live[slot] && tlb_page[slot] == page) begin
                    frame = tlb_frame[slot];
                    hit   = 1'b1;
                end
            end
            if (hit) begin
                if (hit_count != CNT_MAX) hit_count = hit_count + 1'b1;
            end else begin
                if (pt_mapped[page]) begin
                    frame = pt_frame[page];
                end else begin
                    fault = 1'b1;
                    // Once every frame is handed out, frame 0 is given again.
                    if (frames_used < PAGE_COUNT) begin
                        frame       = frames_used;
                        frames_used = frames_used + 1;
                    end else begin
                        frame = 0;
                    end
                    pt_mapped[page] = 1'b1;
                    pt_frame[page]  = frame;
                    if (fault_count != CNT_MAX) fault_count = fault_count + 1'b1;
                end
                tlb_live[tlb_victim]  = 1'b1;
                tlb_page[tlb_victim]  = page;
                tlb_frame[tlb_victim] = frame;
                tlb_victim = (tlb_victim + 1) % TLB_ENTRIES;
            end
            want.phys_addr  = ADDR_W'(frame * PAGE_BYTES + offset);
            want.frame      = FRAME_OUT_W'(frame);
            want.tlb_hit    = hit;
            want.page_fault = fault;
            want.hits       = hit_count;
            want.faults     = fault_count;
            pending_xlat.push_back(want);
        endfunction

        function void field_check(input string name, input logic [CNT_W-1:0] want,
                                  input logic [CNT_W-1:0] seen);
            if (want !== seen) begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, seen);
                error_count++;
            end
        endfunction

        function void check_result(input t_xlat seen);
            t_xlat want;
            if (pending_xlat.size() == 0) begin
                $display("%0t: result with no request pending, physical_address %0h",
                         $time, seen.phys_addr);
                error_count++;
                return;
            end
            want = pending_xlat.pop_front();
            field_check("physical_address", want.phys_addr, seen.phys_addr);
            field_check("frame_number", want.frame, seen.frame);
            field_check("tlb_hit", want.tlb_hit, seen.tlb_hit);
            field_check("page_fault", want.page_fault, seen.page_fault);
            field_check("hits_so_far", want.hits, seen.hits);
            field_check("faults_so_far", want.faults, seen.faults);
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic [ADDR_W-1:0]      i_logical_address;
    logic                   o_result_valid;
    logic [ADDR_W-1:0]      o_physical_address;
    logic [FRAME_OUT_W-1:0] o_frame_number;
    logic                   o_tlb_hit;
    logic                   o_page_fault;
    logic [CNT_W-1:0]       o_hits_so_far;
    logic [CNT_W-1:0]       o_faults_so_far;

    xlat_scoreboard    translations = new();
    logic [PAGE_W-1:0] recent_pages [$];
    logic [PAGE_W-1:0] fresh_pages [$];
    bit                page_touched [PAGE_COUNT];
    int unsigned       cycle_count;

    tlb_page_table_translator_core #(
        .TLB_ENTRIES(TLB_ENTRIES),
        .PAGE_BYTES (PAGE_BYTES),
        .PAGE_COUNT (PAGE_COUNT)
    ) u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_logical_address (i_logical_address),
        .o_result_valid    (o_result_valid),
        .o_physical_address(o_physical_address),
        .o_frame_number    (o_frame_number),
        .o_tlb_hit         (o_tlb_hit),
        .o_page_fault      (o_page_fault),
        .o_hits_so_far     (o_hits_so_far),
        .o_faults_so_far   (o_faults_so_far)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_result_valid === 1'b1) begin
            translations.check_result('{o_physical_address, o_frame_number, o_tlb_hit,
                                        o_page_fault, o_hits_so_far, o_faults_so_far});
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    // Holds start low for the gap given in its argument, then offers the request until it is taken.
    task automatic send_request(input logic [ADDR_W-1:0] addr, input int gap);
        logic [PAGE_W-1:0] page;
        page = PAGE_W'((addr / PAGE_BYTES) % PAGE_COUNT);
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start             <= 1'b1;
        i_logical_address <= addr;
        do @(posedge i_clk); while (busy !== 1'b0);
        translations.note_request(addr);
        page_touched[page] = 1'b1;
        recent_pages.push_back(page);
        if (recent_pages.size() > RECENT_DEPTH) void'(recent_pages.pop_front());
    endtask

    task automatic wait_results_done();
        @(negedge i_clk);
        start <= 1'b0;
        while (translations.pending_xlat.size() != 0) @(posedge i_clk);
    endtask

    // Mixes pages likely still in the TLB, pages never used, and pages drawn at random.
    function automatic logic [ADDR_W-1:0] pick_address();
        int unsigned       roll;
        logic [PAGE_W-1:0] page;
        roll = $urandom_range(0, 99);
        while (fresh_pages.size() > 0 && page_touched[fresh_pages[0]])
            void'(fresh_pages.pop_front());
        if (roll < 45 && recent_pages.size() > 0)
            page = recent_pages[$urandom_range(0, recent_pages.size() - 1)];
        else if (roll >= 62 && fresh_pages.size() > 0)
            page = fresh_pages.pop_front();
        else
            page = PAGE_W'($urandom_range(0, PAGE_COUNT - 1));
        return ADDR_W'(page * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1));
    endfunction

    initial begin
        logic [ADDR_W-1:0] directed [$];
        logic [PAGE_W-1:0] swap_page;
        int                pick;
        bit                calm;
        i_rst_n           = 1'b0;
        start             = 1'b0;
        i_logical_address = '0;
        for (int k = 0; k < PAGE_COUNT; k++) fresh_pages.push_back(PAGE_W'(k));
        for (int k = PAGE_COUNT - 1; k > 0; k--) begin
            pick             = $urandom_range(0, k);
            swap_page        = fresh_pages[k];
            fresh_pages[k]   = fresh_pages[pick];
            fresh_pages[pick] = swap_page;
        end

        // Field extremes and alternating bits, with hits right after the faults.
        directed = '{16'h0000, 16'h00FF, 16'hFFFF, 16'hFF00, 16'h5555, 16'hAAAA, 16'h55AA};
        // Sixteen new pages push the first entries out of the TLB; the last two requests
        // then miss in the TLB but find their pages already mapped.
        for (int k = 0; k < TLB_ENTRIES; k++)
            directed.push_back(ADDR_W'((16 + k) * PAGE_BYTES + k * 17));
        directed.push_back(16'h0000);
        directed.push_back(16'hFF80);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k]) send_request(directed[k], $urandom_range(0, 7));

        calm = 1'b0;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 50 == 0) calm = ($urandom_range(0, 2) == 0);
            if (n % 150 == 75) wait_results_done();
            send_request(pick_address(), calm ? 0 : $urandom_range(0, 7));
        end

        wait_results_done();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (translations.error_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
